// ----- src/tbp_pkg.sv -----
package tbp_pkg;

    localparam int INDEX_BITS   = 11;
    localparam int HISTORY_BITS = 11;
    localparam int PC_W         = 32;

    typedef logic [1:0] t_cnt;

    localparam t_cnt CNT_STRONG_TAKEN  = 2'd3;
    localparam t_cnt CNT_STRONG_GSHARE = 2'd0;
    localparam t_cnt CNT_MAX           = 2'd3;
    localparam t_cnt CNT_MIN           = 2'd0;

    function automatic t_cnt train(input t_cnt c, input logic up);
        t_cnt r;
        if (up) begin
            r = (c == CNT_MAX) ? CNT_MAX : t_cnt'(c + 2'd1);
        end else begin
            r = (c == CNT_MIN) ? CNT_MIN : t_cnt'(c - 2'd1);
        end
        return r;
    endfunction

endpackage

// ----- src/tbp_if.sv -----
interface tbp_in_if;
    logic                      valid;
    logic                      ready;
    logic [tbp_pkg::PC_W-1:0]  branch_pc;
    logic                      taken;

    modport source (output valid, output branch_pc, output taken, input ready);
    modport sink   (input valid, input branch_pc, input taken, output ready);
endinterface

interface tbp_out_if;
    logic valid;
    logic ready;
    logic bimodal_says_taken;
    logic gshare_says_taken;
    logic used_bimodal;
    logic final_prediction;
    logic was_correct;

    modport source (
        output valid, output bimodal_says_taken, output gshare_says_taken,
        output used_bimodal, output final_prediction, output was_correct,
        input ready
    );
    modport sink (
        input valid, input bimodal_says_taken, input gshare_says_taken,
        input used_bimodal, input final_prediction, input was_correct,
        output ready
    );
endinterface

// ----- src/tbp_ram.sv -----
module tbp_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 2048,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/tbp_table.sv -----
module tbp_table #(
    parameter int INDEX_BITS = tbp_pkg::INDEX_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_re,
    input  logic [INDEX_BITS-1:0] i_raddr,
    input  logic                  i_we,
    input  logic [INDEX_BITS-1:0] i_waddr,
    input  tbp_pkg::t_cnt         i_wdata,
    output tbp_pkg::t_cnt         o_cnt
);

    tbp_pkg::t_cnt r_byp_data;
    logic          r_byp_vld;
    tbp_pkg::t_cnt ram_rdata;

    tbp_ram #(
        .WIDTH ($bits(tbp_pkg::t_cnt)),
        .DEPTH (2 ** INDEX_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_we),
        .i_waddr (i_waddr),
        .i_wdata (i_wdata),
        .i_re    (i_re),
        .i_raddr (i_raddr),
        .o_rdata (ram_rdata)
    );

    // forward a write that lands on the address being read in the same cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp_vld <= 1'b0;
        end else if (i_re) begin
            r_byp_vld <= i_we && (i_waddr == i_raddr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_byp_data <= i_wdata;
        end
    end

    assign o_cnt = r_byp_vld ? r_byp_data : ram_rdata;

endmodule

// ----- src/tournament_branch_predictor_core.sv -----
// Tournament branch predictor (bimodal + gshare with a per-address chooser),
// trained by resolved branches. One branch word is accepted every cycle while
// the output is not stalled and no clearing runs. The branch address indexes
// three 2-bit counter RAMs at acceptance; the registered read data is trained
// and written back as the branch enters the output register; a write-to-read
// bypass in each table covers back-to-back branches that hit the same entry.
// The output register lets one more branch enter while a result waits. After
// reset the block writes reset counter values into all 2**INDEX_BITS entries
// (2048 by default) of all three tables, one entry per cycle, input ready low.
module tournament_branch_predictor_core #(
    parameter int INDEX_BITS   = tbp_pkg::INDEX_BITS,
    parameter int HISTORY_BITS = tbp_pkg::HISTORY_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    tbp_in_if.sink           i_br,
    tbp_out_if.source        o_res
);

    localparam int HW = (INDEX_BITS > HISTORY_BITS) ? INDEX_BITS : HISTORY_BITS;

    logic                    r_clr_busy;
    logic [INDEX_BITS-1:0]   r_clr_idx;
    logic [HISTORY_BITS-1:0] r_hist;
    logic                    r_s1_vld;
    logic [INDEX_BITS-1:0]   r_s1_idx;
    logic [INDEX_BITS-1:0]   r_s1_gidx;
    logic                    r_s1_taken;
    logic                    r_out_vld;
    logic                    r_out_bim;
    logic                    r_out_gsh;
    logic                    r_out_use_bim;
    logic                    r_out_final;
    logic                    r_out_correct;

    logic                    acc;
    logic                    s1_adv;
    logic [INDEX_BITS-1:0]   idx_in;
    logic [INDEX_BITS-1:0]   gidx_in;
    logic [HW-1:0]           hist_w;
    tbp_pkg::t_cnt           bc;
    tbp_pkg::t_cnt           gc;
    tbp_pkg::t_cnt           sc;
    logic                    bim;
    logic                    gsh;
    logic                    use_bim;
    logic                    final_pred;
    logic                    wr_en;
    logic [INDEX_BITS-1:0]   wr_idx;
    logic [INDEX_BITS-1:0]   wr_gidx;
    tbp_pkg::t_cnt           wr_bc;
    tbp_pkg::t_cnt           wr_gc;
    tbp_pkg::t_cnt           wr_sc;

    assign s1_adv     = r_s1_vld && (!r_out_vld || o_res.ready);
    assign i_br.ready = !r_clr_busy && (!r_s1_vld || s1_adv);
    assign acc        = i_br.valid && i_br.ready;

    assign idx_in  = i_br.branch_pc[INDEX_BITS-1:0];
    assign hist_w  = HW'(r_hist);
    assign gidx_in = idx_in ^ hist_w[INDEX_BITS-1:0];

    assign bim        = bc[1];
    assign gsh        = gc[1];
    assign use_bim    = sc[1];
    assign final_pred = use_bim ? bim : gsh;

    assign wr_en   = r_clr_busy || s1_adv;
    assign wr_idx  = r_clr_busy ? r_clr_idx : r_s1_idx;
    assign wr_gidx = r_clr_busy ? r_clr_idx : r_s1_gidx;

    always_comb begin
        if (r_clr_busy) begin
            wr_bc = tbp_pkg::CNT_STRONG_TAKEN;
            wr_gc = tbp_pkg::CNT_STRONG_TAKEN;
            wr_sc = tbp_pkg::CNT_STRONG_GSHARE;
        end else begin
            wr_bc = tbp_pkg::train(bc, r_s1_taken);
            wr_gc = tbp_pkg::train(gc, r_s1_taken);
            wr_sc = (bim != gsh) ? tbp_pkg::train(sc, bim == r_s1_taken) : sc;
        end
    end

    tbp_table #(.INDEX_BITS(INDEX_BITS)) u_bim (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_re (acc), .i_raddr (idx_in),
        .i_we (wr_en), .i_waddr (wr_idx), .i_wdata (wr_bc),
        .o_cnt (bc)
    );

    tbp_table #(.INDEX_BITS(INDEX_BITS)) u_gsh (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_re (acc), .i_raddr (gidx_in),
        .i_we (wr_en), .i_waddr (wr_gidx), .i_wdata (wr_gc),
        .o_cnt (gc)
    );

    tbp_table #(.INDEX_BITS(INDEX_BITS)) u_cho (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_re (acc), .i_raddr (idx_in),
        .i_we (wr_en), .i_waddr (wr_idx), .i_wdata (wr_sc),
        .o_cnt (sc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clr_busy) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (&r_clr_idx) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '0;
        end else if (acc) begin
            r_hist <= HISTORY_BITS'({r_hist, i_br.taken});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (acc) begin
            r_s1_vld <= 1'b1;
        end else if (s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_idx   <= idx_in;
            r_s1_gidx  <= gidx_in;
            r_s1_taken <= i_br.taken;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_adv) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_bim     <= bim;
            r_out_gsh     <= gsh;
            r_out_use_bim <= use_bim;
            r_out_final   <= final_pred;
            r_out_correct <= (final_pred == r_s1_taken);
        end
    end

    assign o_res.valid              = r_out_vld;
    assign o_res.bimodal_says_taken = r_out_bim;
    assign o_res.gshare_says_taken  = r_out_gsh;
    assign o_res.used_bimodal       = r_out_use_bim;
    assign o_res.final_prediction   = r_out_final;
    assign o_res.was_correct        = r_out_correct;

endmodule

// ----- src/tbp_checker.sv -----
module tbp_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_bim,
    input logic i_out_gsh,
    input logic i_out_use_bim,
    input logic i_out_final,
    input logic i_out_correct
);

    logic in_acc;
    assign in_acc = i_in_valid && i_in_ready;

    // hold the result word while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result valid dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_out_bim) && $stable(i_out_gsh) && $stable(i_out_use_bim)
            && $stable(i_out_final) && $stable(i_out_correct))
        else $error("result payload changed while stalled");

    // table clearing follows reset
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready)
        else $error("branch accepted during table clearing");

    // an accepted branch reaches the output through stage 1 and the output register
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> ##1 i_out_valid)
        else $error("no result two cycles after accepted branch");

endmodule

bind tournament_branch_predictor_core tbp_checker u_tbp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_br.valid),
    .i_in_ready    (i_br.ready),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_out_bim     (o_res.bimodal_says_taken),
    .i_out_gsh     (o_res.gshare_says_taken),
    .i_out_use_bim (o_res.used_bimodal),
    .i_out_final   (o_res.final_prediction),
    .i_out_correct (o_res.was_correct)
);
